>>> rtl/idbm_pkg.sv
package idbm_pkg;

  localparam int IN_W    = 8;
  localparam int TOTAL_W = 32;
  localparam int SUM_W   = 34;

  localparam logic [TOTAL_W-1:0] SAT_TOTAL = '1;

  typedef struct packed {
    logic [IN_W-1:0] balloon_value;
    logic            last_balloon;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] max_total;
    logic               count_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_VI,
    S_VJ,
    S_VIJ,
    S_SPLIT,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } state_t;

  // per-split control travelling alongside the memory read data
  typedef struct packed {
    logic valid;
    logic left_adj;
    logic right_adj;
    logic clear_best;
  } split_ctl_t;

endpackage

>>> rtl/idbm_split_eval.sv
module idbm_split_eval #(
  parameter int VW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  idbm_pkg::split_ctl_t      ctl,
  input  logic [2*VW-1:0]           vij,
  input  logic [VW-1:0]             vk,
  input  logic [idbm_pkg::TOTAL_W-1:0] dp_left,
  input  logic [idbm_pkg::TOTAL_W-1:0] dp_right,
  output logic [idbm_pkg::TOTAL_W-1:0] best
);
  import idbm_pkg::*;

  localparam int PW = 3 * VW;

  logic [TOTAL_W-1:0] left_term;
  logic [TOTAL_W-1:0] right_term;
  logic [PW-1:0]      prod;
  logic [TOTAL_W:0]   pair_sum;
  logic               s2_valid;
  logic [SUM_W-1:0]   total;
  logic [TOTAL_W-1:0] total_sat;

  // adjacent-pair entries are zero by definition
  assign left_term  = ctl.left_adj  ? '0 : dp_left;
  assign right_term = ctl.right_adj ? '0 : dp_right;

  assign total     = SUM_W'(pair_sum) + SUM_W'(prod);
  assign total_sat = (total[SUM_W-1:TOTAL_W] != '0) ? SAT_TOTAL : total[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= PW'(vij) * PW'(vk);
    pair_sum <= {1'b0, left_term} + {1'b0, right_term};
    if (ctl.clear_best) begin
      best <= '0;
    end else if (s2_valid && (total_sat > best)) begin
      best <= total_sat;
    end
  end

endmodule

>>> rtl/interval_dp_burst_max.sv
// load: one balloon per cycle while busy is low; the flagged last balloon starts the solve
// solve: each interval of length L runs a value fetch, L-1 split reads, a drain and a write-back;
//   n = count+2 slots give (n-L) intervals of each length L=2..n-1
// the result strobe is high for one cycle right after the final interval is written
// throughput is set by the single split pipeline reading the interval memory, one split a cycle
// reset clears control only; memories are not cleared, adjacent-pair entries are forced to zero
module interval_dp_burst_max #(
  parameter int MAX_BALLOONS = 64,
  parameter int VALUE_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  idbm_pkg::in_item_t  item,
  output logic                busy,
  output logic                result_valid,
  output idbm_pkg::out_item_t result
);
  import idbm_pkg::*;

  localparam int SLOTS = MAX_BALLOONS + 2;
  localparam int DEPTH = SLOTS * SLOTS;
  localparam int VW    = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_BALLOONS + 1);
  localparam int AW    = $clog2(DEPTH);

  localparam logic [AW-1:0] ROW_STEP = AW'(SLOTS);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BALLOONS);

  // control state
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] loaded_count;
  logic          overflow_seen;
  split_ctl_t    ctl_issue;
  split_ctl_t    ctl_s1;

  // sequencer registers
  logic [IW-1:0] last_idx;
  logic [IW-1:0] len_idx;
  logic [IW-1:0] i_idx;
  logic [IW-1:0] j_idx;
  logic [IW-1:0] k_idx;
  logic [AW-1:0] ibase;
  logic [AW-1:0] addr_l;
  logic [AW-1:0] addr_r;
  logic          drain_cnt;

  // value path
  logic [VW-1:0]   vi;
  logic [2*VW-1:0] vij;
  logic [VW-1:0]   rd_v;
  logic            rd_sent;
  logic [VW-1:0]   vk_eff;
  logic [IW-1:0]   v_rd_addr;

  // interval table path
  logic [TOTAL_W-1:0] dp_l;
  logic [TOTAL_W-1:0] dp_r;
  logic [TOTAL_W-1:0] best;
  logic [AW-1:0]      wr_addr;

  logic accept;
  logic store_ok;
  logic k_last;

  // balloon values, one slot per position; sentinels are substituted on read
  logic [VW-1:0]      value_mem [SLOTS];
  // interval table, row i at i*SLOTS
  logic [TOTAL_W-1:0] dp_mem [DEPTH];

  assign busy     = (state != S_LOAD);
  assign accept   = start && !busy;
  assign store_ok = (loaded_count < CNT_MAX);
  assign k_last   = (k_idx == (j_idx - IW'(1)));
  assign wr_addr  = ibase + AW'(j_idx);

  // slot 0 and slot n-1 read as the constant one
  assign vk_eff = rd_sent ? VW'(1) : rd_v;

  assign result_valid          = (state == S_DONE);
  assign result.max_total      = best;
  assign result.count_overflow = overflow_seen;

  always_comb begin
    unique case (state)
      S_VI:    v_rd_addr = i_idx;
      S_VJ:    v_rd_addr = j_idx;
      default: v_rd_addr = k_idx;
    endcase
  end

  // value memory: write during load, one read per cycle during solve
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      value_mem[IW'(loaded_count) + IW'(1)] <= item.balloon_value[VW-1:0];
    end
    rd_v    <= value_mem[v_rd_addr];
    rd_sent <= (v_rd_addr == '0) || (v_rd_addr == last_idx);
  end

  // interval memory: two reads for dp[i][k] and dp[k][j], one write-back per interval
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      dp_mem[wr_addr] <= best;
    end
    dp_l <= dp_mem[addr_l];
    dp_r <= dp_mem[addr_r];
  end

  // next state and issue control
  always_comb begin
    state_next           = state;
    ctl_issue.valid      = (state == S_SPLIT);
    ctl_issue.left_adj   = (k_idx == (i_idx + IW'(1)));
    ctl_issue.right_adj  = k_last;
    ctl_issue.clear_best = (state == S_VI);
    unique case (state)
      S_LOAD: begin
        if (accept && item.last_balloon) begin
          state_next = S_VI;
        end
      end
      S_VI:  state_next = S_VJ;
      S_VJ:  state_next = S_VIJ;
      S_VIJ: state_next = S_SPLIT;
      S_SPLIT: begin
        if (k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_cnt) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if ((j_idx == last_idx) && (len_idx == last_idx)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_VI;
        end
      end
      S_DONE:  state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      ctl_s1        <= '0;
    end else begin
      state  <= state_next;
      ctl_s1 <= ctl_issue;
      if (accept) begin
        if (store_ok) begin
          loaded_count <= loaded_count + CW'(1);
        end else begin
          // extra balloons are dropped, the flag sticks until the result goes out
          overflow_seen <= 1'b1;
        end
      end
      if (state == S_DONE) begin
        loaded_count  <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // interval sequencing: by length, then by start position, then by split
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (accept && item.last_balloon) begin
          last_idx <= IW'(loaded_count) + (store_ok ? IW'(2) : IW'(1));
          len_idx  <= IW'(2);
          i_idx    <= '0;
          j_idx    <= IW'(2);
          ibase    <= '0;
        end
      end
      S_VI: begin
        addr_l    <= ibase + AW'(i_idx) + AW'(1);
        addr_r    <= ibase + ROW_STEP + AW'(j_idx);
        k_idx     <= i_idx + IW'(1);
        drain_cnt <= 1'b0;
      end
      S_VJ: begin
        vi <= vk_eff;
      end
      S_VIJ: begin
        vij <= (2*VW)'(vi) * (2*VW)'(vk_eff);
      end
      S_SPLIT: begin
        k_idx  <= k_idx + IW'(1);
        addr_l <= addr_l + AW'(1);
        addr_r <= addr_r + ROW_STEP;
      end
      S_DRAIN: begin
        drain_cnt <= 1'b1;
      end
      S_WRITE: begin
        if (j_idx == last_idx) begin
          len_idx <= len_idx + IW'(1);
          i_idx   <= '0;
          j_idx   <= len_idx + IW'(1);
          ibase   <= '0;
        end else begin
          i_idx <= i_idx + IW'(1);
          j_idx <= j_idx + IW'(1);
          ibase <= ibase + ROW_STEP;
        end
      end
      S_DONE: begin
        drain_cnt <= 1'b0;
      end
      default: begin
        drain_cnt <= 1'b0;
      end
    endcase
  end

  // product, pair sum, saturation and running maximum
  idbm_split_eval #(
    .VW(VW)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_s1),
    .vij      (vij),
    .vk       (vk_eff),
    .dp_left  (dp_l),
    .dp_right (dp_r),
    .best     (best)
  );

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // the result follows the write-back of the whole-range interval
  a_result_after_write: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_WRITE))
    else $error("result without preceding write-back");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_MAX)
    else $error("loaded count beyond capacity");

  // splits stay strictly inside the open interval
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> ((k_idx > i_idx) && (k_idx < j_idx)))
    else $error("split index outside interval");

  a_interval_shape: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> ((j_idx <= last_idx) && ((j_idx - i_idx) == len_idx)))
    else $error("interval bounds inconsistent at write-back");

endmodule
